@@ design/bps_pkg.sv @@
// shared types, codes and sizes of the byte pattern scanner
`default_nettype none
package bps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int MAX_HITS    = 32;
  localparam int MIN_PATTERN = 4;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int IDX_W       = $clog2(MAX_PATTERN);      // pattern byte index
  localparam int LEN_W       = 6;                        // pattern_len register
  localparam int FILL_W      = $clog2(MAX_PATTERN);      // run fill, 0..WIN_DEPTH
  localparam int HIT_W       = 6;                        // hit count
  localparam int PAT_WORDS   = 4;
  localparam int PAT_BITS    = PAT_WORDS * 64;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;

  typedef logic [7:0] byte_t;

  // input commands
  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_BREAK  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // operations handed from front to back
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_BREAK  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  // result kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // register indexes, 8 bytes apart
  typedef enum logic [2:0] {
    REG_PATTERN_LEN   = 3'd0,
    REG_PATTERN_WORD0 = 3'd1,
    REG_PATTERN_WORD1 = 3'd2,
    REG_PATTERN_WORD2 = 3'd3,
    REG_PATTERN_WORD3 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    op_t         op;
    byte_t       data;
    logic [31:0] addr;
  } work_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] match_addr;
    logic [5:0]  hit_total;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0]    len_m1;   // effective length minus one
    logic [PAT_BITS-1:0] pat;      // byte 0 in bits 7:0
  } scan_cfg_t;

endpackage
`default_nettype wire

@@ design/bps_cfg.sv @@
// configuration registers behind the apb-style port
`default_nettype none
module bps_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bps_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bps_pkg::DATA_W-1:0] pwdata,
  output logic      [bps_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output bps_pkg::scan_cfg_t             scan_cfg
);
  import bps_pkg::*;

  logic [LEN_W-1:0] len_r;
  logic [63:0]      word_r [PAT_WORDS];
  logic             wr_en;
  reg_idx_t         idx;
  logic [LEN_W-1:0] eff_len;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(MIN_PATTERN);
      for (int i = 0; i < PAT_WORDS; i++) word_r[i] <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PATTERN_LEN:   len_r     <= pwdata[LEN_W-1:0];
        REG_PATTERN_WORD0: word_r[0] <= pwdata;
        REG_PATTERN_WORD1: word_r[1] <= pwdata;
        REG_PATTERN_WORD2: word_r[2] <= pwdata;
        REG_PATTERN_WORD3: word_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PATTERN_LEN:   prdata = DATA_W'(len_r);
      REG_PATTERN_WORD0: prdata = word_r[0];
      REG_PATTERN_WORD1: prdata = word_r[1];
      REG_PATTERN_WORD2: prdata = word_r[2];
      REG_PATTERN_WORD3: prdata = word_r[3];
      default:           prdata = '0;
    endcase
  end

  // clamp length into the legal range
  always_comb begin
    if (len_r < LEN_W'(MIN_PATTERN)) eff_len = LEN_W'(MIN_PATTERN);
    else if (len_r > LEN_W'(MAX_PATTERN)) eff_len = LEN_W'(MAX_PATTERN);
    else eff_len = len_r;
  end

  assign scan_cfg.len_m1 = IDX_W'(eff_len - LEN_W'(1));
  assign scan_cfg.pat    = {word_r[3], word_r[2], word_r[1], word_r[0]};

endmodule
`default_nettype wire

@@ design/bps_front.sv @@
// front end: takes items, sorts out commands, queues work for the back end
`default_nettype none
module bps_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    in_cmd,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic [31:0]   in_byte_addr,
  output logic               work_valid,
  output bps_pkg::work_t     work,
  input  wire logic          work_pop
);
  import bps_pkg::*;

  work_t       q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        take;
  logic        keep;
  work_t       item;

  assign full       = (cnt_r == 2'd2);
  assign take       = push & ~full;
  assign work_valid = (cnt_r != 2'd0);
  assign work       = q_r[rd_ptr_r];

  // classify the command; the unused code is dropped here
  always_comb begin
    item.data = in_data_byte;
    item.addr = in_byte_addr;
    keep      = 1'b1;
    unique case (cmd_t'(in_cmd))
      CMD_BYTE:   item.op = OP_BYTE;
      CMD_BREAK:  item.op = OP_BREAK;
      CMD_FINISH: item.op = OP_FINISH;
      default: begin
        item.op = OP_BYTE;
        keep    = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (take && keep) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (work_pop && work_valid) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    cnt_nxt = cnt_r + 2'(take && keep) - 2'(work_pop && work_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && keep) q_r[wr_ptr_r] <= item;
  end

endmodule
`default_nettype wire

@@ design/bps_back.sv @@
// back end: run window, pattern compare, hit count and result queue
`default_nettype none
module bps_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bps_pkg::scan_cfg_t scan_cfg,
  input  wire logic               work_valid,
  input  wire bps_pkg::work_t     work,
  output logic                    work_pop,
  output logic                    empty,
  input  wire logic               pop,
  output bps_pkg::result_t        result
);
  import bps_pkg::*;

  byte_t             win_r [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [HIT_W-1:0]  hits_r;
  result_t           oq_r [2];
  logic              oq_wr_r, oq_rd_r;
  logic [1:0]        oq_cnt_r, oq_cnt_nxt;

  logic              go;
  logic              capped;
  logic              last_ok;
  logic [WIN_DEPTH-1:0] pos_ok;
  logic              match;
  logic              res_vld;
  result_t           res;
  logic              deq;

  assign go       = work_valid & (oq_cnt_r != 2'd2);
  assign work_pop = go;
  assign capped   = (hits_r >= HIT_W'(MAX_HITS));

  // window slot k lines up with pattern byte k + len - MAX_PATTERN
  always_comb begin
    logic [IDX_W:0] sum;
    sum = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      sum = (IDX_W+1)'(k) + (IDX_W+1)'(scan_cfg.len_m1) + (IDX_W+1)'(1);
      if (sum[IDX_W]) begin
        pos_ok[k] = (win_r[k] == scan_cfg.pat[8*sum[IDX_W-1:0] +: 8]);
      end else begin
        pos_ok[k] = 1'b1;
      end
    end
  end

  assign last_ok = (work.data == scan_cfg.pat[8*scan_cfg.len_m1 +: 8]);
  assign match   = (fill_r >= FILL_W'(scan_cfg.len_m1)) & last_ok & (&pos_ok);

  always_comb begin
    res_vld        = 1'b0;
    res.kind       = KIND_MATCH;
    res.match_addr = work.addr - 32'(scan_cfg.len_m1);
    res.hit_total  = 6'(hits_r + HIT_W'(1));
    if (go) begin
      case (work.op)
        OP_FINISH: begin
          res_vld        = 1'b1;
          res.kind       = KIND_SUMMARY;
          res.match_addr = '0;
          res.hit_total  = 6'(hits_r);
        end
        OP_BYTE: res_vld = ~capped & match;
        default: res_vld = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_DEPTH; k++) win_r[k] <= '0;
      fill_r <= '0;
      hits_r <= '0;
    end else if (go) begin
      case (work.op)
        OP_BREAK: fill_r <= '0;
        OP_FINISH: begin
          for (int k = 0; k < WIN_DEPTH; k++) win_r[k] <= '0;
          fill_r <= '0;
          hits_r <= '0;
        end
        default: begin
          if (!capped) begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) win_r[k] <= win_r[k+1];
            win_r[WIN_DEPTH-1] <= work.data;
            if (fill_r != FILL_W'(WIN_DEPTH)) fill_r <= fill_r + FILL_W'(1);
            if (match) hits_r <= hits_r + HIT_W'(1);
          end
        end
      endcase
    end
  end

  // two-entry result queue
  assign empty  = (oq_cnt_r == 2'd0);
  assign result = oq_r[oq_rd_r];
  assign deq    = pop & ~empty;
  assign oq_cnt_nxt = oq_cnt_r + 2'(res_vld) - 2'(deq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (res_vld) oq_wr_r <= ~oq_wr_r;
      if (deq)     oq_rd_r <= ~oq_rd_r;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) oq_r[oq_wr_r] <= res;
  end

endmodule
`default_nettype wire

@@ design/byte_pattern_scanner_unit.sv @@
// top level of the byte pattern scanner
`default_nettype none
// Streaming byte pattern scanner. Items arrive on a queue-style port (push /
// full): command 0 is a memory byte with its address, 1 is a run break for an
// unmapped page, 2 finishes the scan, and 3 is swallowed without effect. The
// newest bytes of the current run sit in a 31-byte window; when the window
// plus the incoming byte equal the configured pattern (4 to 32 bytes, length
// clamped into that range), a match result carries the address of the first
// matching byte and the running hit count. After 32 hits further bytes are
// ignored until finish. Finish returns a summary result with the hit count
// and clears window, run and count; the pattern registers keep their values.
// Throughput is one item per clock while the result queue has room: the
// front end queues classified items in a two-entry queue, and the back end
// retires one each cycle through a combinational compare and a registered
// window update. Results wait for pop in the two-entry result queue, and
// the back end holds off while it is full. Configuration is an apb-style
// port with 64-bit registers at byte addresses 0, 8, 16, 24 and 32 (length,
// then pattern words 0 to 3). The user must write it only while the block
// is idle; the block itself does not enforce this.
module byte_pattern_scanner_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input item channel
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic [31:0]                in_byte_addr,
  // result channel
  output logic                            empty,
  input  wire logic                       pop,
  output logic                            out_kind,
  output logic [31:0]                     out_match_addr,
  output logic [5:0]                      out_hit_total,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bps_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bps_pkg::DATA_W-1:0] pwdata,
  output logic      [bps_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import bps_pkg::*;

  scan_cfg_t scan_cfg;
  logic      work_valid;
  work_t     work;
  logic      work_pop;
  result_t   result;

  // pattern and length registers
  bps_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .scan_cfg (scan_cfg)
  );

  // accept and classify, queue toward the back end
  bps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_byte_addr (in_byte_addr),
    .work_valid   (work_valid),
    .work         (work),
    .work_pop     (work_pop)
  );

  // window compare, counters and result queue
  bps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_cfg   (scan_cfg),
    .work_valid (work_valid),
    .work       (work),
    .work_pop   (work_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  assign out_kind       = result.kind;
  assign out_match_addr = result.match_addr;
  assign out_hit_total  = result.hit_total;

endmodule
`default_nettype wire

@@ tb/byte_pattern_scanner_unit_test.sv @@
// self-checking testbench for the byte pattern scanner top level
module byte_pattern_scanner_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam int RESET_CYCLES    = 5;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int SETTLE_CYCLES   = 8;     // margin for results still passing through the queues after accept
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int MAX_REPORTS     = 40;
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam int NUM_REGS        = PAT_WORDS + 1;
  localparam int DIRECTED_ROWS   = 20;

  typedef enum int {STYLE_ZERO, STYLE_ONES, STYLE_PAIR, STYLE_RANDOM} word_style_t;

  // one row of the directed table, with the result typed in where it is obvious
  typedef struct packed {
    cmd_t        cmd;
    byte_t       data;
    logic [31:0] addr;
    logic        known;
    result_t     res;
  } stim_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_cmd = CMD_NONE;
  logic [7:0]  in_data_byte = '0;
  logic [31:0] in_byte_addr = '0;

  // result channel
  logic        empty;
  logic        pop = 1'b0;
  logic        out_kind;
  logic [31:0] out_match_addr;
  logic [5:0]  out_hit_total;

  // configuration port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // typed expectation riding along with the item on the bus
  logic    known_valid = 1'b0;
  result_t known_result = '0;
  logic    staged_known_valid = 1'b0;
  result_t staged_known_result = '0;

  // idling knobs: gap and stall chances in percent, and a hold-off request
  int unsigned send_gap_pct = 0;
  int unsigned pop_stall_pct = 0;
  bit          hold_off_req = 1'b0;

  // scanner predictor: registers and run state
  logic [5:0]  cfg_len;
  logic [63:0] cfg_word [PAT_WORDS];
  byte_t       scan_window [WIN_DEPTH];
  int unsigned run_bytes;
  int unsigned hits_so_far;

  // expected results, oldest first
  result_t pending_results [$];

  // bookkeeping
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned matches_seen = 0;
  int unsigned summaries_seen = 0;
  int unsigned capped_results = 0;
  int unsigned input_stall_cycles = 0;

  // directed part, run under reset config: length 4, all-zero pattern
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // finish straight after reset reports zero hits
    '{CMD_FINISH, 8'h00, 32'h0000_0000, 1'b1, '{KIND_SUMMARY, 32'h0, 6'd0}},
    // unused command is swallowed
    '{CMD_NONE,   8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
    // run across the top of the address space, match address wraps
    '{CMD_BYTE,   8'h00, 32'hFFFF_FFFE, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0000, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0001, 1'b1, '{KIND_MATCH, 32'hFFFF_FFFE, 6'd1}},
    '{CMD_BYTE,   8'h00, 32'h0000_0002, 1'b1, '{KIND_MATCH, 32'hFFFF_FFFF, 6'd2}},
    '{CMD_BYTE,   8'hFF, 32'h0000_0003, 1'b0, '0},
    // run break, then a fresh run of four
    '{CMD_BREAK,  8'h00, 32'h0000_0000, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0100, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0101, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0102, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0103, 1'b1, '{KIND_MATCH, 32'h0000_0100, 6'd3}},
    // a break keeps a match from spanning the gap
    '{CMD_BREAK,  8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0200, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0201, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 32'h0000_0202, 1'b0, '0},
    '{CMD_FINISH, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{KIND_SUMMARY, 32'h0, 6'd3}},
    // finish emptied the run
    '{CMD_BYTE,   8'h00, 32'h0000_0000, 1'b0, '0},
    '{CMD_FINISH, 8'h00, 32'h0000_0000, 1'b1, '{KIND_SUMMARY, 32'h0, 6'd0}}
  };

  byte_pattern_scanner_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .in_byte_addr   (in_byte_addr),
    .empty          (empty),
    .pop            (pop),
    .out_kind       (out_kind),
    .out_match_addr (out_match_addr),
    .out_hit_total  (out_hit_total),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #TIMEOUT_NS;
    $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
    $display("byte_pattern_scanner_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // length register clamped into 4..32
  function automatic int unsigned eff_pattern_len();
    int unsigned n;
    n = cfg_len;
    if (n < MIN_PATTERN) n = MIN_PATTERN;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic byte_t pattern_byte_at(int unsigned j);
    return cfg_word[j / 8][(j % 8) * 8 +: 8];
  endfunction

  function automatic void clear_scan_state();
    foreach (scan_window[i]) scan_window[i] = '0;
    run_bytes = 0;
    hits_so_far = 0;
  endfunction

  // append one expected result at the tail of the queue
  function automatic void enqueue_expected(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // advance the scanner by one item, returns 1 when the item yields a result
  function automatic bit scan_step(input cmd_t cmd, input byte_t data,
                                   input logic [31:0] addr, output result_t res);
    int unsigned len;
    bit hit;
    res = '0;
    case (cmd)
      CMD_BREAK: begin
        run_bytes = 0;
        return 1'b0;
      end
      CMD_FINISH: begin
        res.kind = KIND_SUMMARY;
        res.match_addr = '0;
        res.hit_total = hits_so_far[5:0];
        clear_scan_state();
        return 1'b1;
      end
      CMD_NONE: return 1'b0;
      default: ;
    endcase
    // past the hit cap bytes leave no trace
    if (hits_so_far >= MAX_HITS) return 1'b0;
    len = eff_pattern_len();
    hit = 1'b0;
    if (run_bytes >= len - 1) begin
      // newest byte against the last pattern byte, window tail against the rest
      hit = (pattern_byte_at(len - 1) == data);
      for (int j = 0; j < len - 1; j++)
        if (scan_window[MAX_PATTERN - len + j] != pattern_byte_at(j)) hit = 1'b0;
    end
    for (int j = 0; j < WIN_DEPTH - 1; j++) scan_window[j] = scan_window[j + 1];
    scan_window[WIN_DEPTH - 1] = data;
    if (run_bytes < WIN_DEPTH) run_bytes++;
    if (!hit) return 1'b0;
    hits_so_far++;
    res.kind = KIND_MATCH;
    res.match_addr = addr - 32'(len - 1);
    res.hit_total = hits_so_far[5:0];
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scan_monitor
    result_t predicted;
    result_t want;
    bit      produced;
    if (rst_n) begin
      if (push && full) input_stall_cycles++;
      // accepted item: step the predictor, queue what it should produce
      if (push && !full) begin
        produced = scan_step(cmd_t'(in_cmd), in_data_byte, in_byte_addr, predicted);
        if (known_valid) enqueue_expected(known_result);
        else if (produced) enqueue_expected(predicted);
      end
      // accepted result: compare against the oldest expectation
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with nothing expected, kind %0d addr %0h hits %0d",
                     $time, out_kind, out_match_addr, out_hit_total);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (out_kind !== want.kind) note_mismatch("kind", want.kind, out_kind);
          if (out_match_addr !== want.match_addr)
            note_mismatch("match_addr", want.match_addr, out_match_addr);
          if (out_hit_total !== want.hit_total)
            note_mismatch("hit_total", want.hit_total, out_hit_total);
          if (want.kind == KIND_SUMMARY) summaries_seen++;
          else matches_seen++;
          if (want.kind == KIND_MATCH && want.hit_total == MAX_HITS) capped_results++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long counted hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : pop_driver
    int unsigned held;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        pop <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) begin
          @(negedge clk);
          pop <= 1'b0;
        end
        hold_off_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and configuration tasks
  // ---------------------------------------------------------------------------

  // present one item after a random gap, hold it until accepted
  task automatic offer_item(input cmd_t cmd, input byte_t data, input logic [31:0] addr);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_cmd <= cmd;
    in_data_byte <= data;
    in_byte_addr <= addr;
    known_valid <= staged_known_valid;
    known_result <= staged_known_result;
    staged_known_valid = 1'b0;
    do @(posedge clk); while (full);
    if (cmd != CMD_NONE) items_sent++;
  endtask

  // drop push, let every expected result drain, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PATTERN_LEN) cfg_len = value[5:0];
    else cfg_word[int'(idx) - 1] = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_readback(input reg_idx_t idx);
    logic [63:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 3'b000};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (idx == REG_PATTERN_LEN) ? {58'd0, cfg_len} : cfg_word[int'(idx) - 1];
    if (prdata !== want) note_mismatch("register readback", want, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [63:0] make_pattern_word(input word_style_t style);
    logic [63:0] w;
    case (style)
      STYLE_ZERO: w = '0;
      STYLE_ONES: w = '1;
      STYLE_PAIR: begin
        // two-symbol alphabet, gives overlapping and repeated matches
        for (int i = 0; i < 8; i++) w[i * 8 +: 8] = $urandom_range(1) ? 8'h3C : 8'hC3;
      end
      default: w = {$urandom(), $urandom()};
    endcase
    return w;
  endfunction

  // per-phase register setting, extremes and out-of-range lengths included
  task automatic set_up_phase(input int phase);
    logic [5:0]  len_val;
    word_style_t style;
    case (phase)
      0: begin len_val = 6'd0;  style = STYLE_ZERO;   end
      1: begin len_val = 6'd32; style = STYLE_PAIR;   end
      2: begin len_val = 6'd63; style = STYLE_RANDOM; end
      3: begin len_val = 6'd3;  style = STYLE_ONES;   end
      4: begin len_val = 6'd17; style = STYLE_PAIR;   end
      5: begin len_val = 6'd4;  style = STYLE_RANDOM; end
      6: begin len_val = 6'd33; style = STYLE_RANDOM; end
      default: begin
        len_val = 6'($urandom_range(63));
        style = word_style_t'($urandom_range(3));
      end
    endcase
    for (int w = 0; w < PAT_WORDS; w++)
      cfg_write(reg_idx_t'(int'(REG_PATTERN_WORD0) + w), make_pattern_word(style));
    cfg_write(REG_PATTERN_LEN, {58'd0, len_val});
    for (int i = 0; i < NUM_REGS; i++) cfg_readback(reg_idx_t'(i));
  endtask

  // mostly well-formed runs seeded with the pattern, the rest noise
  task automatic random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    int unsigned bad_pos;
    logic [31:0] addr;
    byte_t       b;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(1)) offer_item(CMD_BREAK, 8'($urandom), $urandom());
        // some runs start just below the top of the address space
        addr = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom();
        repeat ($urandom_range(1, 5)) begin
          len = eff_pattern_len();
          if ($urandom_range(99) < 55) begin
            // a copy of the pattern, now and then with one byte spoiled
            bad_pos = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : len;
            for (int j = 0; j < len; j++) begin
              b = pattern_byte_at(j);
              if (j == bad_pos) b = b ^ 8'($urandom_range(1, 255));
              offer_item(CMD_BYTE, b, addr);
              addr++;
            end
          end else begin
            repeat ($urandom_range(1, 8)) begin
              b = $urandom_range(1) ? pattern_byte_at($urandom_range(len - 1))
                                    : 8'($urandom);
              // rare jump in address without a break
              if ($urandom_range(19) == 0) addr = $urandom();
              offer_item(CMD_BYTE, b, addr);
              addr++;
            end
          end
        end
      end else if (pick < 80) begin
        offer_item(CMD_FINISH, 8'($urandom), $urandom());
      end else if (pick < 88) begin
        offer_item(CMD_BREAK, 8'($urandom), $urandom());
      end else if (pick < 95) begin
        offer_item(CMD_NONE, 8'($urandom), $urandom());
      end else begin
        offer_item(CMD_BYTE, 8'($urandom), $urandom());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t row;
    // predictor at its reset values
    cfg_len = 6'd4;
    foreach (cfg_word[i]) cfg_word[i] = '0;
    clear_scan_state();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table under reset config
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      staged_known_valid = row.known;
      staged_known_result = row.res;
      offer_item(row.cmd, row.data, row.addr);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      set_up_phase(phase);
      // idling mode: none, sender gaps, receiver stalls, both
      case (phase % 4)
        0: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_gap_pct = 60; pop_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  pop_stall_pct = 60; end
        default: begin send_gap_pct = 27; pop_stall_pct = 27; end
      endcase
      if (phase == 0) begin
        // all-zero pattern: long run drives the hit count to its cap
        offer_item(CMD_BREAK, 8'h00, 32'h0);
        for (int i = 0; i < 40; i++) offer_item(CMD_BYTE, 8'h00, 32'h1000 + i);
        // break still empties the run while capped, bytes stay ignored
        offer_item(CMD_BREAK, 8'h00, 32'h0);
        for (int i = 0; i < 5; i++) offer_item(CMD_BYTE, 8'h00, 32'h2000 + i);
        offer_item(CMD_FINISH, 8'h00, 32'h0);
      end
      if (phase == 4) begin
        // receiver holds off while summaries pile up and back up the input
        hold_off_req = 1'b1;
        repeat (16) offer_item(CMD_FINISH, 8'($urandom), $urandom());
      end
      random_traffic(ITEMS_PER_PHASE);
    end

    send_gap_pct = 0;
    pop_stall_pct = 0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end

    $display("covered %0d items over %0d register settings, %0d results checked",
             items_sent, PHASES + 1, results_checked);
    $display("%0d matches, %0d summaries, %0d at the hit cap, input stalled %0d cycles",
             matches_seen, summaries_seen, capped_results, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("byte_pattern_scanner_unit verification clean");
    end else begin
      $display("byte_pattern_scanner_unit verification failed");
    end
    $finish;
  end

endmodule
